[rtl/fvls_pkg.sv]
// Package for the flash variable log store.
// Holds the sequencer state type, command and status codes and flash byte marks.
// Used by: flash_variable_log_store, flash_variable_log_store_chk and flash_variable_log_store_tb.
`timescale 1ns / 1ps
`default_nettype none
package fvls_pkg;

  localparam logic [7:0] ST_IN_USE  = 8'h77;
  localparam logic [7:0] ST_INVALID = 8'h00;
  localparam logic [7:0] ERASED     = 8'hFF;

  localparam logic [1:0] CMD_MOUNT = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  localparam logic [7:0] KEY_RESERVED = 8'd254;

  typedef enum logic [5:0] {
    S_CLR, S_IDLE, S_DONE,
    S_PG_RD, S_PG_WR,
    S_TE_RD, S_TE_CHK,
    S_MT0, S_MT1, S_MT2, S_MT3, S_MT4, S_MT_FIN, S_MT_END,
    S_W0, S_W1, S_WS0, S_WS1, S_WS2,
    S_WP0, S_WP1, S_WP2, S_WP3, S_WP4, S_WP5,
    S_CP_ER, S_CP0, S_CP1, S_CP2, S_CPC0, S_CPC1, S_CPC2, S_CP3, S_CE0, S_CE1,
    S_RD0, S_RD1, S_RD2, S_RD3, S_RDE, S_RE0, S_RE1
  } state_t;

endpackage
`default_nettype wire

[rtl/fvls_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fvls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/flash_variable_log_store.sv]
// Flash variable log store: emulated variables in ping-pong flash banks.
// Depends on fvls_pkg and fvls_ram.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | tdata: key, data_value; tuser: command, store_index
//   out_    | out | out_tvalid/tready  | tdata: read_value; tuser: status, compacted
//
// One item at a time. Every flash byte access goes through the single RAM read
// port: a byte read sets the address, then takes the registered data; a program
// reads the byte, then AND-writes it, plus the state that sets it up. Mount walks
// the entry tables to find the live bank and its log end, read walks every entry
// and kills each older duplicate by a program, a write searches for its key. A
// write that compacts erases the other bank, then copies live entries byte by byte.
// After reset a clearing pass sets all STORE_COUNT*2*BANK_BYTES bytes to 0xFF;
// no item is taken during it. A stalled result holds the next finish, not the input.
`timescale 1ns / 1ps
`default_nettype none
module flash_variable_log_store
  import fvls_pkg::*;
#(
  parameter int STORE_COUNT      = 2,
  parameter int BANK_BYTES       = 1024,
  parameter int ENTRY_DATA_BYTES = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] key, [23:8] data_value
  input  wire logic [2:0]  in_tuser,   // [1:0] command, [2] store_index
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // [15:0] read_value
  output logic      [2:0]  out_tuser   // [1:0] status, [2] compacted
);

  localparam int DEPTH = STORE_COUNT * 2 * BANK_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = (STORE_COUNT > 1) ? $clog2(STORE_COUNT) : 1;
  localparam int OW    = $clog2(BANK_BYTES) + 2;
  localparam int APW   = $clog2(BANK_BYTES + 1);
  localparam logic [OW-1:0] BANK_O = OW'(BANK_BYTES);
  localparam logic [OW-1:0] EDB_O  = OW'(ENTRY_DATA_BYTES);
  localparam logic [OW-1:0] EB_O   = OW'(ENTRY_DATA_BYTES + 2);
  localparam logic [OW-1:0] ONE_O  = OW'(1);
  localparam logic [OW-1:0] TWO_O  = OW'(2);
  localparam logic          M_LAST = 1'(ENTRY_DATA_BYTES - 1);

  state_t state_r, state_nxt, pg_ret_r, pg_ret_nxt, te_ret_r, te_ret_nxt;
  logic [AW:0]     clr_r, clr_nxt;
  logic [SW-1:0]   s_r, s_nxt;
  logic [7:0]      id_r, id_nxt, n_r, n_nxt, pg_val_r, pg_val_nxt;
  logic [15:0]     val_r, val_nxt, rv_r, rv_nxt;
  logic            bk_r, bk_nxt, pg_bank_r, pg_bank_nxt;
  logic [OW-1:0]   p_r, p_nxt, q_r, q_nxt, ap_r, ap_nxt, old_at_r, old_at_nxt;
  logic [OW-1:0]   at_r, at_nxt, te1_r, te1_nxt, pg_off_r, pg_off_nxt;
  logic [8:0]      i_r, i_nxt;
  logic            old_r, old_nxt, found_r, found_nxt, m_r, m_nxt, u0_r, u0_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            comp_r, comp_nxt, rd_oob_r;
  logic            out_valid_r, out_valid_nxt;
  logic [15:0]     out_data_r, out_data_nxt;
  logic [2:0]      out_user_r, out_user_nxt;
  logic            act_r [STORE_COUNT];
  logic [APW-1:0]  app_r [STORE_COUNT];
  logic            act_we, act_wval, app_we;
  logic [APW-1:0]  app_wval;

  logic            mem_bank, mem_we, clr_sel;
  logic [OW-1:0]   mem_off;
  logic [7:0]      mem_wdata, ram_rdata, byte_q, dbyte;
  logic [AW-1:0]   mem_addr;
  logic [OW-1:0]   te_res, ao, ap_cur, p_step;
  logic [SW-1:0]   in_s;
  logic            in_acc;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign in_s       = SW'(in_tuser[2]);

  assign byte_q = rd_oob_r ? ERASED : ram_rdata;
  assign te_res = (p_r > BANK_O) ? BANK_O : p_r;
  assign ao     = (OW'(app_r[s_r]) == '0) ? ONE_O : OW'(app_r[s_r]);
  assign ap_cur = ao;
  assign p_step = OW'(p_r + OW'(byte_q) + TWO_O);
  assign dbyte  = (ENTRY_DATA_BYTES == 2 && !m_r) ? val_r[15:8] : val_r[7:0];

  assign mem_addr = clr_sel ? clr_r[AW-1:0]
                  : AW'(AW'({s_r, mem_bank}) * AW'(BANK_BYTES)) + AW'(mem_off);

  fvls_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_flash (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .raddr (mem_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < STORE_COUNT; k++) begin
        act_r[k] <= 1'b0;
        app_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (act_we) act_r[s_r] <= act_wval;
      if (app_we) app_r[s_r] <= app_wval;
    end
  end

  always_ff @(posedge clk) begin
    pg_ret_r   <= pg_ret_nxt;
    te_ret_r   <= te_ret_nxt;
    s_r        <= s_nxt;
    id_r       <= id_nxt;
    n_r        <= n_nxt;
    pg_val_r   <= pg_val_nxt;
    val_r      <= val_nxt;
    rv_r       <= rv_nxt;
    bk_r       <= bk_nxt;
    pg_bank_r  <= pg_bank_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    ap_r       <= ap_nxt;
    old_at_r   <= old_at_nxt;
    at_r       <= at_nxt;
    te1_r      <= te1_nxt;
    pg_off_r   <= pg_off_nxt;
    i_r        <= i_nxt;
    old_r      <= old_nxt;
    found_r    <= found_nxt;
    m_r        <= m_nxt;
    u0_r       <= u0_nxt;
    status_r   <= status_nxt;
    comp_r     <= comp_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    rd_oob_r   <= (mem_off >= BANK_O);
  end

  always_comb begin
    state_nxt     = state_r;
    pg_ret_nxt    = pg_ret_r;
    te_ret_nxt    = te_ret_r;
    clr_nxt       = clr_r;
    s_nxt         = s_r;
    id_nxt        = id_r;
    n_nxt         = n_r;
    pg_val_nxt    = pg_val_r;
    val_nxt       = val_r;
    rv_nxt        = rv_r;
    bk_nxt        = bk_r;
    pg_bank_nxt   = pg_bank_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    ap_nxt        = ap_r;
    old_at_nxt    = old_at_r;
    at_nxt        = at_r;
    te1_nxt       = te1_r;
    pg_off_nxt    = pg_off_r;
    i_nxt         = i_r;
    old_nxt       = old_r;
    found_nxt     = found_r;
    m_nxt         = m_r;
    u0_nxt        = u0_r;
    status_nxt    = status_r;
    comp_nxt      = comp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    act_we        = 1'b0;
    act_wval      = 1'b0;
    app_we        = 1'b0;
    app_wval      = '0;
    mem_bank      = bk_r;
    mem_off       = '0;
    mem_we        = 1'b0;
    mem_wdata     = ERASED;
    clr_sel       = 1'b0;

    unique case (state_r)
      S_CLR: begin
        clr_sel = 1'b1;
        mem_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          s_nxt      = in_s;
          id_nxt     = in_tdata[7:0] + 8'd1;
          val_nxt    = in_tdata[23:8];
          status_nxt = STAT_OK;
          rv_nxt     = '0;
          comp_nxt   = 1'b0;
          p_nxt      = ONE_O;
          found_nxt  = 1'b0;
          old_nxt    = 1'b0;
          state_nxt  = S_DONE;
          if (32'(in_tuser[2]) < STORE_COUNT) begin
            unique case (in_tuser[1:0])
              CMD_MOUNT: state_nxt = S_MT0;
              CMD_WRITE: begin
                if (in_tdata[7:0] >= KEY_RESERVED) status_nxt = STAT_FULL;
                else state_nxt = S_W0;
              end
              CMD_READ: begin
                bk_nxt = act_r[in_s];
                if (in_tdata[7:0] >= KEY_RESERVED) status_nxt = STAT_NOT_FOUND;
                else state_nxt = S_RD0;
              end
              default: state_nxt = S_DONE;
            endcase
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rv_r;
          out_user_nxt  = {comp_r, status_r};
          state_nxt     = S_IDLE;
        end
      end
      // program: read the byte, write old AND new
      S_PG_RD: begin
        mem_bank  = pg_bank_r;
        mem_off   = pg_off_r;
        state_nxt = S_PG_WR;
      end
      S_PG_WR: begin
        mem_bank  = pg_bank_r;
        mem_off   = pg_off_r;
        mem_we    = !rd_oob_r;
        mem_wdata = byte_q & pg_val_r;
        state_nxt = pg_ret_r;
      end
      // table end walk on bank bk_r from p
      S_TE_RD: begin
        mem_off = p_r;
        if (p_r >= BANK_O) state_nxt = te_ret_r;
        else state_nxt = S_TE_CHK;
      end
      S_TE_CHK: begin
        if (byte_q == ERASED) state_nxt = te_ret_r;
        else begin
          p_nxt     = p_step;
          state_nxt = S_TE_RD;
        end
      end
      S_MT0: begin
        mem_bank  = 1'b0;
        state_nxt = S_MT1;
      end
      S_MT1: begin
        u0_nxt    = (byte_q == ST_IN_USE);
        mem_bank  = 1'b1;
        state_nxt = S_MT2;
      end
      S_MT2: begin
        if (u0_r && byte_q == ST_IN_USE) begin
          bk_nxt     = 1'b1;
          p_nxt      = ONE_O;
          te_ret_nxt = S_MT3;
          state_nxt  = S_TE_RD;
        end else if (u0_r) begin
          bk_nxt    = 1'b0;
          state_nxt = S_MT_FIN;
        end else if (byte_q == ST_IN_USE) begin
          bk_nxt    = 1'b1;
          state_nxt = S_MT_FIN;
        end else begin
          bk_nxt      = 1'b0;
          pg_bank_nxt = 1'b0;
          pg_off_nxt  = '0;
          pg_val_nxt  = ST_IN_USE;
          pg_ret_nxt  = S_MT_FIN;
          state_nxt   = S_PG_RD;
        end
      end
      S_MT3: begin
        te1_nxt    = te_res;
        bk_nxt     = 1'b0;
        p_nxt      = ONE_O;
        te_ret_nxt = S_MT4;
        state_nxt  = S_TE_RD;
      end
      S_MT4: begin
        // keep the shorter table, bank 1 on a tie
        bk_nxt      = (te1_r <= te_res);
        pg_bank_nxt = !(te1_r <= te_res);
        pg_off_nxt  = '0;
        pg_val_nxt  = ST_INVALID;
        pg_ret_nxt  = S_MT_FIN;
        state_nxt   = S_PG_RD;
      end
      S_MT_FIN: begin
        p_nxt      = ONE_O;
        te_ret_nxt = S_MT_END;
        state_nxt  = S_TE_RD;
      end
      S_MT_END: begin
        act_we    = 1'b1;
        act_wval  = bk_r;
        app_we    = 1'b1;
        app_wval  = APW'(te_res);
        state_nxt = S_DONE;
      end
      S_W0: begin
        app_we   = 1'b1;
        app_wval = APW'(ao);
        if (OW'(ao + EDB_O + ONE_O) >= BANK_O) begin
          comp_nxt  = 1'b1;
          bk_nxt    = act_r[s_r];
          p_nxt     = '0;
          state_nxt = S_CP_ER;
        end else begin
          state_nxt = S_W1;
        end
      end
      S_W1: begin
        if (OW'(ap_cur + EB_O) > BANK_O) begin
          status_nxt = STAT_FULL;
          state_nxt  = S_DONE;
        end else begin
          ap_nxt    = ap_cur;
          bk_nxt    = act_r[s_r];
          p_nxt     = ONE_O;
          old_nxt   = 1'b0;
          state_nxt = S_WS0;
        end
      end
      S_WS0: begin
        mem_off   = OW'(p_r + ONE_O);
        state_nxt = S_WS1;
      end
      S_WS1: begin
        mem_off = p_r;
        if (byte_q == id_r) begin
          old_nxt    = 1'b1;
          old_at_nxt = OW'(p_r + ONE_O);
          state_nxt  = S_WP0;
        end else if (p_r >= BANK_O) begin
          state_nxt = S_WP0;
        end else begin
          state_nxt = S_WS2;
        end
      end
      S_WS2: begin
        if (byte_q == ERASED) state_nxt = S_WP0;
        else begin
          p_nxt     = p_step;
          state_nxt = S_WS0;
        end
      end
      S_WP0: begin
        m_nxt       = 1'b0;
        pg_bank_nxt = bk_r;
        pg_off_nxt  = ap_r;
        pg_val_nxt  = 8'(ENTRY_DATA_BYTES);
        pg_ret_nxt  = S_WP1;
        state_nxt   = S_PG_RD;
      end
      S_WP1: begin
        pg_off_nxt = OW'(ap_r + TWO_O + OW'(m_r));
        pg_val_nxt = dbyte;
        pg_ret_nxt = S_WP2;
        state_nxt  = S_PG_RD;
      end
      S_WP2: begin
        if (m_r == M_LAST) state_nxt = S_WP3;
        else begin
          m_nxt     = 1'b1;
          state_nxt = S_WP1;
        end
      end
      S_WP3: begin
        pg_off_nxt = OW'(ap_r + ONE_O);
        pg_val_nxt = id_r;
        pg_ret_nxt = S_WP4;
        state_nxt  = S_PG_RD;
      end
      S_WP4: begin
        if (old_r) begin
          pg_off_nxt = old_at_r;
          pg_val_nxt = 8'h00;
          pg_ret_nxt = S_WP5;
          state_nxt  = S_PG_RD;
        end else begin
          state_nxt = S_WP5;
        end
      end
      S_WP5: begin
        app_we    = 1'b1;
        app_wval  = APW'(OW'(ap_r + EB_O));
        state_nxt = S_DONE;
      end
      // compaction: erase the other bank, copy live entries
      S_CP_ER: begin
        mem_bank = !bk_r;
        mem_off  = p_r;
        mem_we   = 1'b1;
        if (p_r == OW'(BANK_BYTES - 1)) begin
          p_nxt     = ONE_O;
          q_nxt     = ONE_O;
          state_nxt = S_CP0;
        end else begin
          p_nxt = OW'(p_r + ONE_O);
        end
      end
      S_CP0: begin
        mem_off = p_r;
        if (p_r >= BANK_O) state_nxt = S_CE0;
        else state_nxt = S_CP1;
      end
      S_CP1: begin
        mem_off = OW'(p_r + ONE_O);
        n_nxt   = byte_q;
        if (byte_q == ERASED) state_nxt = S_CE0;
        else state_nxt = S_CP2;
      end
      S_CP2: begin
        i_nxt = '0;
        if (byte_q != 8'h00 && byte_q != ERASED) state_nxt = S_CPC0;
        else state_nxt = S_CP3;
      end
      S_CPC0: begin
        mem_off   = OW'(p_r + OW'(i_r));
        state_nxt = S_CPC1;
      end
      S_CPC1: begin
        pg_bank_nxt = !bk_r;
        pg_off_nxt  = q_r;
        pg_val_nxt  = byte_q;
        pg_ret_nxt  = S_CPC2;
        state_nxt   = S_PG_RD;
      end
      S_CPC2: begin
        q_nxt = OW'(q_r + ONE_O);
        i_nxt = i_r + 9'd1;
        if (i_r + 9'd1 == {1'b0, n_r} + 9'd2) state_nxt = S_CP3;
        else state_nxt = S_CPC0;
      end
      S_CP3: begin
        p_nxt     = OW'(p_r + OW'(n_r) + TWO_O);
        state_nxt = S_CP0;
      end
      S_CE0: begin
        app_we      = 1'b1;
        app_wval    = APW'((q_r > BANK_O) ? BANK_O : q_r);
        act_we      = 1'b1;
        act_wval    = !bk_r;
        pg_bank_nxt = !bk_r;
        pg_off_nxt  = '0;
        pg_val_nxt  = ST_IN_USE;
        pg_ret_nxt  = S_CE1;
        state_nxt   = S_PG_RD;
      end
      S_CE1: begin
        pg_bank_nxt = bk_r;
        pg_off_nxt  = '0;
        pg_val_nxt  = ST_INVALID;
        pg_ret_nxt  = S_W1;
        state_nxt   = S_PG_RD;
      end
      // read: walk the log, kill older duplicates
      S_RD0: begin
        mem_off = p_r;
        if (p_r >= BANK_O) state_nxt = S_RDE;
        else state_nxt = S_RD1;
      end
      S_RD1: begin
        mem_off = OW'(p_r + ONE_O);
        n_nxt   = byte_q;
        if (byte_q == ERASED) state_nxt = S_RDE;
        else state_nxt = S_RD2;
      end
      S_RD2: begin
        state_nxt = S_RD3;
        if (byte_q == id_r) begin
          found_nxt = 1'b1;
          at_nxt    = p_r;
          if (found_r) begin
            pg_bank_nxt = bk_r;
            pg_off_nxt  = OW'(at_r + ONE_O);
            pg_val_nxt  = 8'h00;
            pg_ret_nxt  = S_RD3;
            state_nxt   = S_PG_RD;
          end
        end
      end
      S_RD3: begin
        p_nxt     = OW'(p_r + OW'(n_r) + TWO_O);
        state_nxt = S_RD0;
      end
      S_RDE: begin
        m_nxt = 1'b0;
        if (found_r) state_nxt = S_RE0;
        else begin
          status_nxt = STAT_NOT_FOUND;
          state_nxt  = S_DONE;
        end
      end
      S_RE0: begin
        mem_off   = OW'(at_r + TWO_O + OW'(m_r));
        state_nxt = S_RE1;
      end
      S_RE1: begin
        rv_nxt = {rv_r[7:0], byte_q};
        if (m_r == M_LAST) state_nxt = S_DONE;
        else begin
          m_nxt     = 1'b1;
          state_nxt = S_RE0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[test/flash_variable_log_store_chk.sv]
// Checker for the flash variable log store: predicts one result per accepted item
// from its own flash image and compares it with each accepted result item.
// Depends on fvls_pkg.
`timescale 1ns / 1ps
module flash_variable_log_store_chk
  import fvls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] key, [23:8] data_value
  input  logic [2:0]  in_tuser,   // [1:0] command, [2] store_index
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [15:0] read_value
  input  logic [2:0]  out_tuser,  // [1:0] status, [2] compacted
  output int          fail_count,
  output int          pending,
  output int          compactions
);

  localparam int BANK = 1024;
  localparam int EDB  = 2;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] value;
    logic        compacted;
  } answer_t;

  logic [7:0] flash_img [4096];
  int         next_free [2];
  bit         live_bank [2];
  answer_t    answer_q [$];

  function automatic int fl_rd(bit s, bit b, int off);
    if (off >= BANK) return ERASED;
    return flash_img[(2 * s + b) * BANK + off];
  endfunction

  function automatic void fl_prog(bit s, bit b, int off, logic [7:0] v);
    if (off < BANK) flash_img[(2 * s + b) * BANK + off] &= v;
  endfunction

  function automatic int log_end(bit s, bit b);
    int p;
    p = 1;
    while (p < BANK && fl_rd(s, b, p) != ERASED) p += fl_rd(s, b, p) + 2;
    return p > BANK ? BANK : p;
  endfunction

  function automatic void mount_store(bit s);
    bit u0, u1, b;
    u0 = fl_rd(s, 0, 0) == ST_IN_USE;
    u1 = fl_rd(s, 1, 0) == ST_IN_USE;
    if (u0 && u1) begin
      // keep the shorter table, bank 1 on a tie
      b = log_end(s, 1) <= log_end(s, 0);
      fl_prog(s, !b, 0, ST_INVALID);
    end else if (u0 || u1) begin
      b = u1 && !u0;
    end else begin
      b = 0;
      fl_prog(s, 0, 0, ST_IN_USE);
    end
    live_bank[s] = b;
    next_free[s] = log_end(s, b);
  endfunction

  function automatic void compact_store(bit s);
    bit src, dst;
    int p, q, n, k;
    src = live_bank[s];
    dst = !src;
    for (int i = 0; i < BANK; i++) flash_img[(2 * s + dst) * BANK + i] = ERASED;
    p = 1;
    q = 1;
    while (p < BANK && fl_rd(s, src, p) != ERASED) begin
      n = fl_rd(s, src, p);
      k = fl_rd(s, src, p + 1);
      if (k != ST_INVALID && k != ERASED) begin
        for (int i = 0; i < n + 2; i++) begin
          fl_prog(s, dst, q, fl_rd(s, src, p + i));
          q++;
        end
      end
      p += n + 2;
    end
    next_free[s] = q > BANK ? BANK : q;
    live_bank[s] = dst;
    fl_prog(s, dst, 0, ST_IN_USE);
    fl_prog(s, src, 0, ST_INVALID);
  endfunction

  function automatic answer_t predict_answer(logic [1:0] cmd, bit s, logic [7:0] key,
                                             logic [15:0] val);
    answer_t r;
    int p, ap, at;
    bit b, hit;
    logic [7:0] id;
    r = '0;
    id = key + 8'd1;
    case (cmd)
      CMD_MOUNT: mount_store(s);
      CMD_WRITE: begin
        if (key >= KEY_RESERVED) begin
          r.status = STAT_FULL;
        end else begin
          if (next_free[s] < 1) next_free[s] = 1;
          if (next_free[s] + EDB + 1 >= BANK) begin
            compact_store(s);
            r.compacted = 1'b1;
          end
          ap = next_free[s] < 1 ? 1 : next_free[s];
          if (ap + EDB + 2 > BANK) begin
            r.status = STAT_FULL;
          end else begin
            b = live_bank[s];
            p = 1;
            while (p < BANK && fl_rd(s, b, p + 1) != id && fl_rd(s, b, p) != ERASED)
              p += fl_rd(s, b, p) + 2;
            hit = fl_rd(s, b, p + 1) == id;
            at = p + 1;
            fl_prog(s, b, ap, EDB);
            fl_prog(s, b, ap + 2, val[15:8]);
            fl_prog(s, b, ap + 3, val[7:0]);
            fl_prog(s, b, ap + 1, id);
            if (hit) fl_prog(s, b, at, ST_INVALID);
            next_free[s] = ap + EDB + 2;
          end
        end
      end
      CMD_READ: begin
        hit = 0;
        at = 0;
        b = live_bank[s];
        if (key < KEY_RESERVED) begin
          p = 1;
          while (p < BANK && fl_rd(s, b, p) != ERASED) begin
            if (fl_rd(s, b, p + 1) == id) begin
              // kill the older duplicate, the newer one wins
              if (hit) fl_prog(s, b, at + 1, ST_INVALID);
              hit = 1;
              at = p;
            end
            p += fl_rd(s, b, p) + 2;
          end
        end
        if (hit) r.value = {8'(fl_rd(s, b, at + 2)), 8'(fl_rd(s, b, at + 3))};
        else r.status = STAT_NOT_FOUND;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < 4096; i++) flash_img[i] = ERASED;
      next_free = '{0, 0};
      live_bank = '{0, 0};
      answer_q.delete();
      fail_count <= 0;
      compactions <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        want = predict_answer(in_tuser[1:0], in_tuser[2], in_tdata[7:0], in_tdata[23:8]);
        if (want.compacted) compactions <= compactions + 1;
        answer_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tuser[1:0], out_tdata, out_tuser[2]};
        if (answer_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result item %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = answer_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: status %0d/%0d value %h/%h compacted %0d/%0d (exp/act)",
                       want.status, got.status, want.value, got.value,
                       want.compacted, got.compacted);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = answer_q.size();
  end

endmodule

[test/flash_variable_log_store_tb.sv]
// Top of the flash variable log store bench: clock, reset, stimulus, idling and verdict.
// Depends on fvls_pkg, flash_variable_log_store and flash_variable_log_store_chk.
`timescale 1ns / 1ps
module flash_variable_log_store_tb;
  import fvls_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int         STALL_LIMIT = 60000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;
  int          fail_count, pending, compactions;
  int          send_idle = 26, recv_idle = 86;
  bit          hold_req = 0;
  int          quiet = 0;

  flash_variable_log_store u_dut (.*);

  flash_variable_log_store_chk u_chk (.*);

  initial forever #2 clk = ~clk;

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold = 700;
        hold_req = 0;
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= $urandom_range(99) >= recv_idle;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_cmd(logic [1:0] cmd, bit s, logic [7:0] key, logic [15:0] val);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {val, key};
    in_tuser  <= {s, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    int n, r;
    bit s;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: unmounted store, reserved keys, extremes, every command
    send_cmd(CMD_WRITE, 1, 8'd7, 16'hA5A5);
    send_cmd(CMD_READ, 1, 8'd7, 16'h0);
    send_cmd(CMD_MOUNT, 1, 8'd0, 16'h0);
    send_cmd(CMD_READ, 1, 8'd7, 16'hFFFF);
    send_cmd(CMD_MOUNT, 0, 8'd0, 16'h0);
    send_cmd(CMD_READ, 0, 8'd5, 16'h0);
    send_cmd(CMD_WRITE, 0, 8'd0, 16'h0000);
    send_cmd(CMD_WRITE, 0, 8'd253, 16'hFFFF);
    send_cmd(CMD_WRITE, 0, 8'd0, 16'h1234);
    send_cmd(CMD_READ, 0, 8'd0, 16'h0);
    send_cmd(CMD_READ, 0, 8'd253, 16'h0);
    send_cmd(CMD_WRITE, 0, 8'd254, 16'hBEEF);
    send_cmd(CMD_WRITE, 0, 8'd255, 16'hBEEF);
    send_cmd(CMD_READ, 0, 8'd254, 16'h0);
    send_cmd(CMD_READ, 0, 8'd255, 16'h0);
    send_cmd(CMD_NONE, 1, 8'hFF, 16'hFFFF);
    send_cmd(CMD_WRITE, 0, 8'hAA, 16'h5555);
    send_cmd(CMD_WRITE, 0, 8'h55, 16'hAAAA);
    send_cmd(CMD_READ, 0, 8'hAA, 16'h0);
    send_cmd(CMD_MOUNT, 0, 8'd0, 16'h0);
    send_cmd(CMD_READ, 0, 8'h55, 16'h0);

    // random: mostly writes to one store so its log fills and compacts
    n = 0;
    while (n < 270 || (compactions < 1 && n < 310)) begin
      if (n == 90) begin
        send_idle = 86;
        recv_idle = 26;
        hold_req = 1;
      end else if (n == 180) begin
        send_idle = 0;
        recv_idle = 0;
      end
      r = $urandom_range(99);
      s = $urandom_range(99) < 3;
      if (r < 1)
        send_cmd(CMD_MOUNT, s, $urandom_range(255), $urandom_range(16'hFFFF));
      else if (r < 95)
        send_cmd(CMD_WRITE, s, ($urandom_range(9) == 0) ? $urandom_range(255)
                 : $urandom_range(15), $urandom_range(16'hFFFF));
      else if (r < 99)
        send_cmd(CMD_READ, s, ($urandom_range(9) == 0) ? $urandom_range(255)
                 : $urandom_range(17), $urandom_range(16'hFFFF));
      else
        send_cmd(CMD_NONE, s, $urandom_range(255), $urandom_range(16'hFFFF));
      n++;
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

[flash_variable_log_store.f]
rtl/fvls_pkg.sv
rtl/fvls_ram.sv
rtl/flash_variable_log_store.sv
test/flash_variable_log_store_chk.sv
test/flash_variable_log_store_tb.sv
